FILE: hdl/walker_wall_collision_step_top_assert.svh
// Assertion macros for the walker collision step block.
// Used by walker_wall_collision_step_top; expects clk and rst_n in scope.
`ifndef WALKER_WALL_COLLISION_STEP_TOP_ASSERT_SVH
`define WALKER_WALL_COLLISION_STEP_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WWCS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define WWCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/wwcs_pkg.sv
// Shared types, constants and saturating arithmetic for the walker collision step.
// No dependencies.
package wwcs_pkg;

    localparam int MAX_WALLS = 16;
    localparam int WALL_AW   = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CNT_W     = $clog2(MAX_WALLS + 1);

    typedef logic signed [31:0] q16_t;
    typedef logic signed [32:0] q16w_t;

    localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q16_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CMD_WALL  = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_PLACE = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_RADIUS  = 3'd0,
        CFG_HEIGHT  = 3'd1,
        CFG_GRAVITY = 3'd2,
        CFG_FLOOR   = 3'd3,
        CFG_WALLS   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        q16_t lo_x;
        q16_t lo_y;
        q16_t lo_z;
        q16_t hi_x;
        q16_t hi_y;
        q16_t hi_z;
    } wall_t;

    typedef struct packed {
        logic             start;
        logic             along_x;
        logic             delta_pos;
        logic [CNT_W-1:0] count;
    } scan_ctrl_t;

    typedef struct packed {
        logic busy;
        logic upd_valid;
        q16_t upd_value;
    } scan_stat_t;

    function automatic q16w_t ext33(q16_t v);
        return {v[31], v};
    endfunction

    // a + b saturated to the signed 32-bit range
    function automatic q16_t sat_add(q16_t a, q16w_t b);
        logic signed [33:0] s;
        s = {{2{a[31]}}, a} + {b[32], b};
        if (!s[33] && (s[32] || s[31])) begin
            return Q16_MAX;
        end
        if (s[33] && !(s[32] && s[31])) begin
            return Q16_MIN;
        end
        return s[31:0];
    endfunction

endpackage

FILE: hdl/wwcs_if.sv
// Command and result channel interfaces for the walker collision step.
// No dependencies.
interface wwcs_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [3:0]         wall_slot;
    logic signed [31:0] vec_a_x;
    logic signed [31:0] vec_a_y;
    logic signed [31:0] vec_a_z;
    logic signed [31:0] vec_b_x;
    logic signed [31:0] vec_b_y;
    logic signed [31:0] vec_b_z;
    logic [15:0]        time_step;

    modport source (
        output valid, cmd, wall_slot, vec_a_x, vec_a_y, vec_a_z,
        output vec_b_x, vec_b_y, vec_b_z, time_step,
        input  ready
    );
    modport sink (
        input  valid, cmd, wall_slot, vec_a_x, vec_a_y, vec_a_z,
        input  vec_b_x, vec_b_y, vec_b_z, time_step,
        output ready
    );
endinterface

interface wwcs_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_vertical_speed;
    logic               out_grounded;

    modport source (
        output valid, out_x, out_y, out_z, out_vertical_speed, out_grounded,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_vertical_speed, out_grounded,
        output ready
    );
endinterface

FILE: hdl/wwcs_wall_scan.sv
// Wall table memory and pipelined push-out scan along one axis.
// Depends on wwcs_pkg.
module wwcs_wall_scan
    import wwcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  scan_ctrl_t         ctrl,
    input  logic [30:0]        radius,
    input  q16_t               feet_y,
    input  q16_t               head_y,
    input  q16_t               walker_x,
    input  q16_t               walker_z,
    input  logic               wr_en,
    input  logic [WALL_AW-1:0] wr_addr,
    input  wall_t              wr_wall,
    output scan_stat_t         stat
);

    wall_t wall_mem [MAX_WALLS];

    logic             active_reg, active_next;
    logic [CNT_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic             along_x_reg, along_x_next;
    logic             dpos_reg, dpos_next;
    logic             rd_v_reg, grow_v_reg;
    logic             issuing;

    wall_t rd_wall_reg;
    q16_t  lx_reg, hx_reg, lz_reg, hz_reg;
    logic  vhit_reg;

    q16w_t rad_pos, rad_neg;
    logic  contained;

    assign issuing = active_reg && (iss_cnt_reg != lim_reg);
    assign rad_pos = $signed({2'b00, radius});
    assign rad_neg = -rad_pos;

    always_comb
    begin
        active_next  = active_reg;
        iss_cnt_next = iss_cnt_reg;
        lim_next     = lim_reg;
        along_x_next = along_x_reg;
        dpos_next    = dpos_reg;
        if (ctrl.start)
        begin
            active_next  = 1'b1;
            iss_cnt_next = '0;
            lim_next     = ctrl.count;
            along_x_next = ctrl.along_x;
            dpos_next    = ctrl.delta_pos;
        end
        else if (active_reg)
        begin
            if (issuing)
            begin
                iss_cnt_next = iss_cnt_reg + 1'b1;
            end
            else if (!rd_v_reg && !grow_v_reg)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            iss_cnt_reg <= '0;
            lim_reg     <= '0;
            along_x_reg <= 1'b0;
            dpos_reg    <= 1'b0;
            rd_v_reg    <= 1'b0;
            grow_v_reg  <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            iss_cnt_reg <= iss_cnt_next;
            lim_reg     <= lim_next;
            along_x_reg <= along_x_next;
            dpos_reg    <= dpos_next;
            rd_v_reg    <= issuing;
            grow_v_reg  <= rd_v_reg;
        end
    end

    // wall table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wall_mem[wr_addr] <= wr_wall;
        end
        rd_wall_reg <= wall_mem[iss_cnt_reg[WALL_AW-1:0]];
    end

    // grow stage: widen the box by the radius, check vertical overlap
    always_ff @(posedge clk)
    begin
        lx_reg   <= sat_add(rd_wall_reg.lo_x, rad_neg);
        hx_reg   <= sat_add(rd_wall_reg.hi_x, rad_pos);
        lz_reg   <= sat_add(rd_wall_reg.lo_z, rad_neg);
        hz_reg   <= sat_add(rd_wall_reg.hi_z, rad_pos);
        vhit_reg <= (feet_y < rd_wall_reg.hi_y) && (head_y > rd_wall_reg.lo_y);
    end

    // test stage works on the live walker position
    assign contained = vhit_reg && (walker_x > lx_reg) && (walker_x < hx_reg)
                       && (walker_z > lz_reg) && (walker_z < hz_reg);

    always_comb
    begin
        stat.busy      = active_reg;
        stat.upd_valid = grow_v_reg && contained;
        if (along_x_reg)
        begin
            stat.upd_value = dpos_reg ? lx_reg : hx_reg;
        end
        else
        begin
            stat.upd_value = dpos_reg ? lz_reg : hz_reg;
        end
    end

endmodule

FILE: hdl/walker_wall_collision_step_top.sv
// Walker collision step: top level with command sequencer, shared multiplier
// and walker state. Depends on wwcs_pkg, wwcs_if, wwcs_wall_scan and the
// assertion macro header.
//
// Usage: commands arrive as words on cmd_ch (valid/ready). Each word gives
// exactly one result word on res_ch carrying the walker state after it.
// Wall write, place and no-op words go through the execute and done states.
// Step word: each axis streams the N walls in use (capped at MAX_WALLS)
// through a read/grow/test pipeline, one wall per cycle, and drains it,
// plus one shared 32x17 multiplier pass per velocity, gravity and fall term.
// One word is worked on at a time; cmd_ch.ready is high only when idle.
// The result sits in an output register, so a new word is accepted while
// the previous result waits; if res_ch stalls, the next finished result
// holds in the final state until the register frees up.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wr_data),
// to be written only while the block is idle.
// Reset: walker state clears to zero, config registers take defaults; the
// wall table is not cleared and a slot must be written before it is used.
`include "walker_wall_collision_step_top_assert.svh"

module walker_wall_collision_step_top
    import wwcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wwcs_cmd_if.sink    cmd_ch,
    wwcs_res_if.source  res_ch,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_EXEC  = 10'b00_0000_0010,
        S_ADDX  = 10'b00_0000_0100,
        S_SCANX = 10'b00_0000_1000,
        S_ADDZ  = 10'b00_0001_0000,
        S_SCANZ = 10'b00_0010_0000,
        S_GRAV  = 10'b00_0100_0000,
        S_MULV  = 10'b00_1000_0000,
        S_FALL  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [30:0] radius_reg, radius_next;
    logic [30:0] height_reg, height_next;
    logic [30:0] gravity_reg, gravity_next;
    q16_t        floor_reg, floor_next;
    logic [4:0]  walls_reg, walls_next;

    // walker state
    q16_t x_reg, x_next;
    q16_t y_reg, y_next;
    q16_t z_reg, z_next;
    q16_t vs_reg, vs_next;
    logic on_floor_reg, on_floor_next;

    // captured command word
    cmd_t        cmd_reg, cmd_next;
    logic [3:0]  slot_reg, slot_next;
    q16_t        ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    q16_t        bx_reg, bx_next, by_reg, by_next, bz_reg, bz_next;
    logic [15:0] dt_reg, dt_next;

    // step datapath
    q16_t               head_reg, head_next;
    logic signed [47:0] prod_reg, prod_next;
    q16_t               mul_a;
    logic signed [16:0] dt_s;
    logic signed [48:0] prod_full;
    q16_t               delta;
    logic               delta_pos;
    q16_t               y_fall;

    // result register
    logic out_valid_reg, out_valid_next;
    q16_t ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next, ovs_reg, ovs_next;
    logic og_reg, og_next;

    // scan unit
    scan_ctrl_t         scan_ctrl;
    scan_stat_t         scan_stat;
    logic               wr_en;
    logic [WALL_AW-1:0] wr_addr;
    wall_t              wr_wall;
    logic [CNT_W-1:0]   walls_tested;

    // single shared multiplier: operand times dt, floor(/65536) by the shift
    assign dt_s      = $signed({1'b0, dt_reg});
    assign prod_full = mul_a * dt_s;
    assign delta     = prod_reg[47:16];
    assign delta_pos = !delta[31] && (delta != '0);
    assign y_fall    = sat_add(y_reg, ext33(delta));

    assign walls_tested = (32'(walls_reg) > MAX_WALLS) ? CNT_W'(MAX_WALLS)
                                                       : CNT_W'(walls_reg);

    assign wr_addr = WALL_AW'(slot_reg);
    assign wr_wall = '{lo_x: ax_reg, lo_y: ay_reg, lo_z: az_reg,
                       hi_x: bx_reg, hi_y: by_reg, hi_z: bz_reg};

    wwcs_wall_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .radius   (radius_reg),
        .feet_y   (y_reg),
        .head_y   (head_reg),
        .walker_x (x_reg),
        .walker_z (z_reg),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_wall  (wr_wall),
        .stat     (scan_stat)
    );

    assign cmd_ch.ready              = (state_reg == S_IDLE);
    assign res_ch.valid              = out_valid_reg;
    assign res_ch.out_x              = ox_reg;
    assign res_ch.out_y              = oy_reg;
    assign res_ch.out_z              = oz_reg;
    assign res_ch.out_vertical_speed = ovs_reg;
    assign res_ch.out_grounded       = og_reg;

    always_comb
    begin
        state_next     = state_reg;
        radius_next    = radius_reg;
        height_next    = height_reg;
        gravity_next   = gravity_reg;
        floor_next     = floor_reg;
        walls_next     = walls_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        vs_next        = vs_reg;
        on_floor_next  = on_floor_reg;
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        bz_next        = bz_reg;
        dt_next        = dt_reg;
        head_next      = head_reg;
        prod_next      = prod_reg;
        mul_a          = bx_reg;
        out_valid_next = out_valid_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        ovs_next       = ovs_reg;
        og_next        = og_reg;
        scan_ctrl      = '0;
        wr_en          = 1'b0;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_RADIUS:  radius_next  = cfg_wr_data[30:0];
                CFG_HEIGHT:  height_next  = cfg_wr_data[30:0];
                CFG_GRAVITY: gravity_next = cfg_wr_data[30:0];
                CFG_FLOOR:   floor_next   = cfg_wr_data;
                CFG_WALLS:   walls_next   = cfg_wr_data[4:0];
                default:     ;
            endcase
        end

        if (out_valid_reg && res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_ch.valid)
                begin
                    cmd_next   = cmd_t'(cmd_ch.cmd);
                    slot_next  = cmd_ch.wall_slot;
                    ax_next    = cmd_ch.vec_a_x;
                    ay_next    = cmd_ch.vec_a_y;
                    az_next    = cmd_ch.vec_a_z;
                    bx_next    = cmd_ch.vec_b_x;
                    by_next    = cmd_ch.vec_b_y;
                    bz_next    = cmd_ch.vec_b_z;
                    dt_next    = cmd_ch.time_step;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_WALL:
                    begin
                        wr_en      = (32'(slot_reg) < MAX_WALLS);
                        state_next = S_DONE;
                    end
                    CMD_PLACE:
                    begin
                        x_next     = ax_reg;
                        y_next     = ay_reg;
                        z_next     = az_reg;
                        vs_next    = bx_reg;
                        state_next = S_DONE;
                    end
                    CMD_STEP:
                    begin
                        mul_a      = bx_reg;
                        prod_next  = prod_full[47:0];
                        head_next  = sat_add(y_reg, $signed({2'b00, height_reg}));
                        state_next = S_ADDX;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ADDX:
            begin
                x_next              = sat_add(x_reg, ext33(delta));
                scan_ctrl.start     = 1'b1;
                scan_ctrl.along_x   = 1'b1;
                scan_ctrl.delta_pos = delta_pos;
                scan_ctrl.count     = walls_tested;
                mul_a               = bz_reg;
                prod_next           = prod_full[47:0];
                state_next          = S_SCANX;
            end
            S_SCANX:
            begin
                if (scan_stat.upd_valid)
                begin
                    x_next = scan_stat.upd_value;
                end
                if (!scan_stat.busy)
                begin
                    state_next = S_ADDZ;
                end
            end
            S_ADDZ:
            begin
                z_next              = sat_add(z_reg, ext33(delta));
                scan_ctrl.start     = 1'b1;
                scan_ctrl.along_x   = 1'b0;
                scan_ctrl.delta_pos = delta_pos;
                scan_ctrl.count     = walls_tested;
                mul_a               = $signed({1'b0, gravity_reg});
                prod_next           = prod_full[47:0];
                state_next          = S_SCANZ;
            end
            S_SCANZ:
            begin
                if (scan_stat.upd_valid)
                begin
                    z_next = scan_stat.upd_value;
                end
                if (!scan_stat.busy)
                begin
                    state_next = S_GRAV;
                end
            end
            S_GRAV:
            begin
                vs_next    = sat_add(vs_reg, -ext33(delta));
                state_next = S_MULV;
            end
            S_MULV:
            begin
                mul_a      = vs_reg;
                prod_next  = prod_full[47:0];
                state_next = S_FALL;
            end
            S_FALL:
            begin
                if (y_fall <= floor_reg)
                begin
                    y_next        = floor_reg;
                    vs_next       = '0;
                    on_floor_next = 1'b1;
                end
                else
                begin
                    y_next        = y_fall;
                    on_floor_next = 1'b0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || res_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    ox_next        = x_reg;
                    oy_next        = y_reg;
                    oz_next        = z_reg;
                    ovs_next       = vs_reg;
                    og_next        = on_floor_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= 31'd32768;
            height_reg    <= 31'd114688;
            gravity_reg   <= 31'd642253;
            floor_reg     <= '0;
            walls_reg     <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            vs_reg        <= '0;
            on_floor_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radius_reg    <= radius_next;
            height_reg    <= height_next;
            gravity_reg   <= gravity_next;
            floor_reg     <= floor_next;
            walls_reg     <= walls_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            vs_reg        <= vs_next;
            on_floor_reg  <= on_floor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        slot_reg <= slot_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        az_reg   <= az_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        bz_reg   <= bz_next;
        dt_reg   <= dt_next;
        head_reg <= head_next;
        prod_reg <= prod_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
        ovs_reg  <= ovs_next;
        og_reg   <= og_next;
    end

    // push-out updates only land while an axis scan is running
    `WWCS_ASSERT_SAME(a_upd_in_scan, scan_stat.upd_valid,
                      (state_reg == S_SCANX) || (state_reg == S_SCANZ),
                      "wall push-out outside a scan")
    // one word in flight: no accept right after an accept
    `WWCS_ASSERT_NEXT(a_one_in_flight, cmd_ch.valid && cmd_ch.ready, !cmd_ch.ready,
                      "second word accepted while busy")
    // landing on the floor kills the vertical speed
    `WWCS_ASSERT_SAME(a_land_stops, $rose(on_floor_reg), vs_reg == '0,
                      "grounded with nonzero vertical speed")

endmodule
